[rtl/rfpl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpl_pkg: shared types and constants of the power leveling loop
// Field widths, register indexes, loop modes, status codes and the
// result of one leveling step.
// ----------------------------------------------------------------------------
package rfpl_pkg;

  // Field widths
  localparam int unsigned AdcW   = 16;
  localparam int unsigned ChW    = 4;
  localparam int unsigned PwrW   = 16;
  localparam int unsigned TgtW   = 15;
  localparam int unsigned SlopeW = 16;
  localparam int unsigned AttW   = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_DET_CHANNEL = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTERCEPT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOPE       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ATTEN   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MIN_ATTEN   = 3'd5;

  // Input action codes
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ARMED = 2'd1,
    MODE_RAISE = 2'd2,
    MODE_LOWER = 2'd3
  } loop_mode_e;

  typedef enum logic [1:0] {
    STAT_STEPPING = 2'd0,
    STAT_SETTLED  = 2'd1,
    STAT_RANGE    = 2'd2
  } loop_status_e;

  // Outcome of one item at the leveling stage
  typedef struct packed {
    loop_mode_e          mode;
    logic [AttW-1:0]     atten;
    logic [TgtW-1:0]     target;
    logic                emit;
    loop_status_e        status;
    logic [PwrW-1:0]     power;
  } step_res_t;

endpackage

[rtl/rfpl_level_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpl_level_step: power conversion and attenuation step decision
// Turns the scaled detector drop into a saturated Q8 dBm power and works
// out the next loop mode, attenuation and status for one item.
// ----------------------------------------------------------------------------
module rfpl_level_step (
  input  logic                          is_start_i,
  input  logic [rfpl_pkg::TgtW-1:0]     cmd_target_i,
  input  logic [rfpl_pkg::PwrW-1:0]     drop_i,
  input  logic [rfpl_pkg::PwrW-1:0]     intercept_i,
  input  logic [rfpl_pkg::AttW-1:0]     step_size_i,
  input  logic [rfpl_pkg::AttW-1:0]     max_atten_i,
  input  logic [rfpl_pkg::AttW-1:0]     min_atten_i,
  input  rfpl_pkg::loop_mode_e          mode_i,
  input  logic [rfpl_pkg::AttW-1:0]     atten_i,
  input  logic [rfpl_pkg::TgtW-1:0]     target_i,
  output rfpl_pkg::step_res_t           res_o
);
  import rfpl_pkg::*;

  logic signed [17:0]   pwr_full;
  logic signed [17:0]   pwr;
  logic signed [17:0]   tgt;
  logic signed [17:0]   band;
  logic [AttW-1:0]      step_eff;
  logic [AttW:0]        up_sum;
  logic [AttW:0]        min_plus;
  logic [PwrW-1:0]      pwr_sat;

  // Convert and saturate the measured power
  always_comb begin
    pwr_full = 18'(signed'(intercept_i)) - signed'({2'b00, drop_i});
    if (pwr_full > 18'sd32767) begin
      pwr_sat = 16'h7fff;
    end else if (pwr_full < -18'sd32768) begin
      pwr_sat = 16'h8000;
    end else begin
      pwr_sat = pwr_full[PwrW-1:0];
    end
  end

  // Step operands
  assign step_eff = (step_size_i == '0) ? AttW'(1) : step_size_i;
  assign pwr      = 18'(signed'(pwr_sat));
  assign tgt      = 18'(signed'(target_i));
  assign band     = signed'({5'b0, step_eff, 7'b0});
  assign up_sum   = {1'b0, atten_i} + {1'b0, step_eff};
  assign min_plus = {1'b0, min_atten_i} + {1'b0, step_eff};

  // Decide the next loop state
  always_comb begin
    loop_mode_e dir;
    dir          = mode_i;
    res_o.mode   = mode_i;
    res_o.atten  = atten_i;
    res_o.target = target_i;
    res_o.emit   = 1'b0;
    res_o.status = STAT_STEPPING;
    res_o.power  = pwr_sat;

    if (is_start_i) begin
      res_o.target = cmd_target_i;
      res_o.mode   = MODE_ARMED;
    end else if (mode_i != MODE_IDLE) begin
      res_o.emit = 1'b1;
      // pick the direction on the first average after a start
      if (mode_i == MODE_ARMED) begin
        if (pwr > tgt) begin
          dir = MODE_RAISE;
        end else if (pwr < tgt) begin
          dir = MODE_LOWER;
        end else begin
          dir = MODE_IDLE;
          res_o.status = STAT_SETTLED;
        end
      end
      res_o.mode = dir;

      case (dir)
        MODE_RAISE: begin
          if (pwr > tgt + band) begin
            if (atten_i < max_atten_i) begin
              res_o.atten = (up_sum > {1'b0, max_atten_i}) ? max_atten_i
                                                           : up_sum[AttW-1:0];
            end else begin
              res_o.mode   = MODE_IDLE;
              res_o.status = STAT_RANGE;
            end
          end else begin
            res_o.mode   = MODE_IDLE;
            res_o.status = STAT_SETTLED;
          end
        end
        MODE_LOWER: begin
          if (pwr < tgt - band) begin
            if (atten_i > min_atten_i) begin
              res_o.atten = ({1'b0, atten_i} >= min_plus) ? atten_i - step_eff
                                                         : min_atten_i;
            end else begin
              res_o.mode   = MODE_IDLE;
              res_o.status = STAT_RANGE;
            end
          end else begin
            res_o.mode   = MODE_IDLE;
            res_o.status = STAT_SETTLED;
          end
        end
        default: begin
          // settled on an exact match, nothing to step
        end
      endcase
    end
  end

endmodule

[rtl/rf_power_leveling_loop.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_power_leveling_loop: step attenuator automatic level control
// Averages detector samples, converts them to Q8 dBm power and steps the
// attenuator toward a commanded target power.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle in steady state unless output
// stalls. Samples of the selected detector channel are summed in groups
// of AVG_COUNT at the input; every completed group and every start command
// runs through a pipeline (average by reciprocal multiply or shift, slope
// multiply, power and step decision). Starts, foreign-channel samples and
// averages taken while the loop is idle give no result. Each stage holds
// its item only while the next is full and stalled, so input stalls only
// when all stages are full. The user must write configuration only while
// the pipeline is empty; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rf_power_leveling_loop #(
  parameter int unsigned AVG_COUNT = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [rfpl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rfpl_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [rfpl_pkg::TgtW-1:0]       target_power_i,
  input  logic [rfpl_pkg::AdcW-1:0]       adc_code_i,
  input  logic [rfpl_pkg::ChW-1:0]        adc_channel_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rfpl_pkg::AttW-1:0]       atten_word_o,
  output logic [rfpl_pkg::AttW-1:0]       atten_level_o,
  output logic [rfpl_pkg::PwrW-1:0]       measured_power_o,
  output logic [1:0]                      loop_status_o
);
  import rfpl_pkg::*;

  localparam int unsigned AvgLog = $clog2(AVG_COUNT);
  localparam int unsigned CntW   = (AvgLog > 0) ? AvgLog : 1;
  localparam int unsigned SumW   = AdcW + AvgLog;
  localparam int unsigned RecSh  = SumW + AvgLog;
  localparam logic [63:0] RecipL = ((64'd1 << RecSh) + 64'(AVG_COUNT) - 64'd1)
                                   / 64'(AVG_COUNT);
  localparam logic [CntW-1:0] CntLast = CntW'(AVG_COUNT - 1);

  // configuration registers
  logic [ChW-1:0]     det_channel_q;
  logic [PwrW-1:0]    intercept_q;
  logic [SlopeW-1:0]  slope_q;
  logic [AttW-1:0]    step_size_q;
  logic [AttW-1:0]    max_atten_q;
  logic [AttW-1:0]    min_atten_q;

  // accumulator and loop state
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CntW-1:0]    count_q;
  loop_mode_e         mode_q;
  logic [AttW-1:0]    atten_q;
  logic [TgtW-1:0]    target_q;

  // pipeline
  logic               s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic               s1_ready, s2_ready, s3_ready;
  logic               s1_start_q, s2_start_q, s3_start_q;
  logic [TgtW-1:0]    s1_target_q, s2_target_q, s3_target_q;
  logic [SumW-1:0]    s1_sum_q;
  logic [AdcW-1:0]    s2_avg_q, avg_d;
  logic [PwrW-1:0]    s3_drop_q;
  logic [AdcW+SlopeW-1:0] drop_prod;

  logic               in_fire, is_sample, ch_match, group_done, in_emit, s3_fire;
  step_res_t          step_res;

  logic [AttW-1:0]    out_level_q;
  logic [PwrW-1:0]    out_power_q;
  loop_status_e       out_status_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_channel_q <= ChW'(5);
      intercept_q   <= PwrW'(3840);
      slope_q       <= SlopeW'(38400);
      step_size_q   <= AttW'(1);
      max_atten_q   <= AttW'(63);
      min_atten_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DET_CHANNEL: det_channel_q <= cfg_wdata_i[ChW-1:0];
        CFG_INTERCEPT:   intercept_q   <= cfg_wdata_i[PwrW-1:0];
        CFG_SLOPE:       slope_q       <= cfg_wdata_i[SlopeW-1:0];
        CFG_STEP_SIZE:   step_size_q   <= cfg_wdata_i[AttW-1:0];
        CFG_MAX_ATTEN:   max_atten_q   <= cfg_wdata_i[AttW-1:0];
        CFG_MIN_ATTEN:   min_atten_q   <= cfg_wdata_i[AttW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage handshakes: a stage moves when the next one is empty or moving
  assign s3_ready   = !out_valid_q || out_ready_i;
  assign s2_ready   = !s3_valid_q || s3_ready;
  assign s1_ready   = !s2_valid_q || s2_ready;
  assign in_ready_o = !s1_valid_q || s1_ready;

  assign in_fire    = in_valid_i && in_ready_o;
  assign is_sample  = (action_i == ACT_SAMPLE);
  assign ch_match   = (adc_channel_i == det_channel_q);
  assign group_done = (count_q == CntLast);
  assign in_emit    = !is_sample || (ch_match && group_done);
  assign sum_d      = sum_q + SumW'(adc_code_i);

  // Accumulate matching samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (in_fire && is_sample && ch_match) begin
      if (group_done) begin
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // Divide the group sum by the group size
  if ((1 << AvgLog) == AVG_COUNT) begin : g_avg_shift
    assign avg_d = s1_sum_q[AvgLog +: AdcW];
  end else begin : g_avg_recip
    logic [2*SumW:0] recip_prod;
    assign recip_prod = s1_sum_q * RecipL[SumW:0];
    assign avg_d      = recip_prod[RecSh +: AdcW];
  end

  assign drop_prod = s2_avg_q * slope_q;

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_fire && in_emit;
      if (s1_ready)   s2_valid_q <= s1_valid_q;
      if (s2_ready)   s3_valid_q <= s2_valid_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_start_q  <= !is_sample;
      s1_target_q <= target_power_i;
      s1_sum_q    <= sum_d;
    end
    if (s1_ready) begin
      s2_start_q  <= s1_start_q;
      s2_target_q <= s1_target_q;
      s2_avg_q    <= avg_d;
    end
    if (s2_ready) begin
      s3_start_q  <= s2_start_q;
      s3_target_q <= s2_target_q;
      s3_drop_q   <= drop_prod[AdcW+SlopeW-1 -: PwrW];
    end
  end

  rfpl_level_step u_level_step (
    .is_start_i   (s3_start_q),
    .cmd_target_i (s3_target_q),
    .drop_i       (s3_drop_q),
    .intercept_i  (intercept_q),
    .step_size_i  (step_size_q),
    .max_atten_i  (max_atten_q),
    .min_atten_i  (min_atten_q),
    .mode_i       (mode_q),
    .atten_i      (atten_q),
    .target_i     (target_q),
    .res_o        (step_res)
  );

  assign s3_fire = s3_valid_q && s3_ready;

  // Advance the loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      atten_q     <= AttW'(63);
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s3_fire) begin
        mode_q   <= step_res.mode;
        atten_q  <= step_res.atten;
        target_q <= step_res.target;
      end
      if (s3_ready) out_valid_q <= s3_fire && step_res.emit;
    end
  end

  // Hold the result item
  always_ff @(posedge clk_i) begin
    if (s3_fire && step_res.emit) begin
      out_level_q  <= step_res.atten;
      out_power_q  <= step_res.power;
      out_status_q <= step_res.status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign atten_level_o    = out_level_q;
  assign atten_word_o     = ~out_level_q;
  assign measured_power_o = out_power_q;
  assign loop_status_o    = out_status_q;

endmodule

[sim/tb_rf_power_leveling_loop.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rf_power_leveling_loop: self-checking bench of the power leveling loop
// Drives start commands and detector samples through the input handshake,
// mirrors the averaging, power conversion and attenuation stepping in a
// local tracker, and compares every result item field by field against the
// queued prediction, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rf_power_leveling_loop;
  import rfpl_pkg::*;

  localparam int unsigned AvgCount    = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned MaxPrinted  = 40;

  typedef struct packed {
    logic [AttW-1:0] word;
    logic [AttW-1:0] level;
    logic [PwrW-1:0] power;
    loop_status_e    status;
  } atten_report_t;

  typedef struct packed {
    logic [ChW-1:0]    channel;
    logic [PwrW-1:0]   intercept;
    logic [SlopeW-1:0] slope;
    logic [AttW-1:0]   step;
    logic [AttW-1:0]   max_att;
    logic [AttW-1:0]   min_att;
  } level_cfg_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                action_i       = ACT_SAMPLE;
  logic [TgtW-1:0]     target_power_i = '0;
  logic [AdcW-1:0]     adc_code_i     = '0;
  logic [ChW-1:0]      adc_channel_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [AttW-1:0]     atten_word_o;
  logic [AttW-1:0]     atten_level_o;
  logic [PwrW-1:0]     measured_power_o;
  logic [1:0]          loop_status_o;

  // Tracker state: register mirror and loop state
  level_cfg_t      cfg_q;
  logic [18:0]     sum_q;
  int unsigned     count_q;
  loop_mode_e      mode_q;
  logic [AttW-1:0] level_q;
  logic [TgtW-1:0] target_q;

  atten_report_t pending_reports[$];

  int unsigned errors          = 0;
  int unsigned items_sent      = 0;
  int unsigned reports_checked = 0;
  int unsigned settings_used   = 0;
  int unsigned burst_left      = 0;
  int unsigned cycles          = 0;
  int unsigned stall_kind      = 0;
  int unsigned stall_span      = 0;

  rf_power_leveling_loop u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .target_power_i   (target_power_i),
    .adc_code_i       (adc_code_i),
    .adc_channel_i    (adc_channel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .atten_word_o     (atten_word_o),
    .atten_level_o    (atten_level_o),
    .measured_power_o (measured_power_o),
    .loop_status_o    (loop_status_o)
  );

  always #5 clk_i = ~clk_i;

  // Count cycles and end a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("run stopped at cycle limit %0d, %0d results still due", CycleLimit,
               pending_reports.size());
      $display("tb_rf_power_leveling_loop failed");
      $finish;
    end
  end

  // Stall the result side in spans of changing character
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_kind <= $urandom_range(0, 3);
      stall_span <= $urandom_range(16, 96);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_kind)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (cycles[1:0] != 2'd3);
    endcase
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    errors++;
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    atten_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing expected", loop_status_o, -1);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (atten_word_o !== want.word) begin
          report_mismatch("atten_word", atten_word_o, want.word);
        end
        if (atten_level_o !== want.level) begin
          report_mismatch("atten_level", atten_level_o, want.level);
        end
        if (measured_power_o !== want.power) begin
          report_mismatch("measured_power", $signed(measured_power_o), $signed(want.power));
        end
        if (loop_status_o !== want.status) begin
          report_mismatch("loop_status", loop_status_o, want.status);
        end
      end
    end
  end

  function automatic level_cfg_t make_cfg(logic [ChW-1:0] ch, logic [PwrW-1:0] icpt,
                                          logic [SlopeW-1:0] slope, logic [AttW-1:0] stp,
                                          logic [AttW-1:0] maxa, logic [AttW-1:0] mina);
    level_cfg_t c;
    c.channel   = ch;
    c.intercept = icpt;
    c.slope     = slope;
    c.step      = stp;
    c.max_att   = maxa;
    c.min_att   = mina;
    return c;
  endfunction

  // Power in Q8 dBm of one average, saturated to 16-bit signed
  function automatic int detector_power(logic [AdcW-1:0] avg);
    logic [31:0] prod;
    int icpt;
    int drop;
    int pw;
    prod = {16'd0, avg} * {16'd0, cfg_q.slope};
    icpt = $signed(cfg_q.intercept);
    drop = prod[31:16];
    pw   = icpt - drop;
    if (pw > 32767) pw = 32767;
    if (pw < -32768) pw = -32768;
    return pw;
  endfunction

  // Detector code that lands close to a wanted power under the current slope
  function automatic logic [AdcW-1:0] code_for_power(int pw);
    longint icpt;
    longint num;
    if (cfg_q.slope == 0) return AdcW'($urandom);
    icpt = $signed(cfg_q.intercept);
    num  = (icpt - pw) * 65536;
    if (num <= 0) return '0;
    num = num / longint'(cfg_q.slope);
    if (num > 65535) return '1;
    return AdcW'(num);
  endfunction

  // Advance the tracker by one accepted item and queue any result it gives
  function automatic void predict_leveling(logic act, logic [TgtW-1:0] tgt,
                                           logic [AdcW-1:0] code, logic [ChW-1:0] ch);
    logic [AdcW-1:0] avg;
    int pw;
    int tgt_i;
    int stp;
    int band;
    int lvl;
    int maxa;
    int mina;
    loop_status_e status;
    atten_report_t rep;
    if (act == ACT_START) begin
      target_q = tgt;
      mode_q   = MODE_ARMED;
      return;
    end
    if (ch != cfg_q.channel) return;
    sum_q = sum_q + code;
    count_q++;
    if (count_q < AvgCount) return;
    avg     = sum_q[18:3];
    sum_q   = '0;
    count_q = 0;
    pw = detector_power(avg);
    if (mode_q == MODE_IDLE) return;

    stp    = (cfg_q.step == 0) ? 1 : cfg_q.step;
    band   = stp * 128;
    tgt_i  = $signed(target_q);
    lvl    = level_q;
    maxa   = cfg_q.max_att;
    mina   = cfg_q.min_att;
    status = STAT_STEPPING;

    // First average after a start picks the direction
    if (mode_q == MODE_ARMED) begin
      if (pw > tgt_i) begin
        mode_q = MODE_RAISE;
      end else if (pw < tgt_i) begin
        mode_q = MODE_LOWER;
      end else begin
        mode_q = MODE_IDLE;
        status = STAT_SETTLED;
      end
    end

    if (mode_q == MODE_RAISE) begin
      if (pw > tgt_i + band) begin
        if (lvl < maxa) begin
          lvl = lvl + stp;
          if (lvl > maxa) lvl = maxa;
        end else begin
          mode_q = MODE_IDLE;
          status = STAT_RANGE;
        end
      end else begin
        mode_q = MODE_IDLE;
        status = STAT_SETTLED;
      end
    end else if (mode_q == MODE_LOWER) begin
      if (pw < tgt_i - band) begin
        if (lvl > mina) begin
          if (lvl >= mina + stp) lvl = lvl - stp;
          else lvl = mina;
        end else begin
          mode_q = MODE_IDLE;
          status = STAT_RANGE;
        end
      end else begin
        mode_q = MODE_IDLE;
        status = STAT_SETTLED;
      end
    end

    level_q    = AttW'(lvl);
    rep.word   = ~level_q;
    rep.level  = level_q;
    rep.power  = PwrW'(pw);
    rep.status = status;
    pending_reports.push_back(rep);
  endfunction

  // Send one item, with a random gap in front of each burst
  task automatic send_item(logic act, logic [TgtW-1:0] tgt, logic [AdcW-1:0] code,
                           logic [ChW-1:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    action_i       <= act;
    target_power_i <= tgt;
    adc_code_i     <= code;
    adc_channel_i  <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    predict_leveling(act, tgt, code, ch);
    items_sent++;
  endtask

  // Drop valid, wait out every due result, then let the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(level_cfg_t c);
    wait_idle();
    write_reg(CFG_DET_CHANNEL, CfgDataW'(c.channel));
    write_reg(CFG_INTERCEPT, c.intercept);
    write_reg(CFG_SLOPE, c.slope);
    write_reg(CFG_STEP_SIZE, CfgDataW'(c.step));
    write_reg(CFG_MAX_ATTEN, CfgDataW'(c.max_att));
    write_reg(CFG_MIN_ATTEN, CfgDataW'(c.min_att));
    cfg_we_i <= 1'b0;
    cfg_q = c;
    settings_used++;
  endtask

  // One group of samples on the detector channel around a code,
  // with now and then a sample from another channel slipped in
  task automatic average_at(logic [AdcW-1:0] code);
    int unsigned n;
    int c;
    for (n = 0; n < AvgCount; n++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(ACT_SAMPLE, TgtW'($urandom), AdcW'($urandom),
                  cfg_q.channel + ChW'($urandom_range(1, 15)));
      end
      c = code;
      if ($urandom_range(0, 1) == 1) c = c + int'($urandom_range(0, 6)) - 3;
      if (c < 0) c = 0;
      if (c > 65535) c = 65535;
      send_item(ACT_SAMPLE, TgtW'($urandom), AdcW'(c), cfg_q.channel);
    end
  endtask

  // Start, then averages that walk from several bands out toward the target
  // and past it, so the loop steps, settles or runs into a limit
  task automatic leveling_sequence();
    logic [TgtW-1:0] tgt;
    int tgt_i;
    int band;
    int dir;
    int k;
    int jitter;
    case ($urandom_range(0, 9))
      0: tgt = 15'h3fff;
      1: tgt = 15'h4000;
      default: tgt = TgtW'($urandom);
    endcase
    tgt_i = $signed(tgt);
    send_item(ACT_START, tgt, AdcW'($urandom), ChW'($urandom));
    band = ((cfg_q.step == 0) ? 1 : cfg_q.step) * 128;
    dir  = ($urandom_range(0, 1) == 1) ? 1 : -1;
    for (k = $urandom_range(0, 5); k >= -2; k--) begin
      if ($urandom_range(0, 3) == 0) jitter = 0;
      else jitter = int'($urandom_range(0, band)) - band / 2;
      average_at(code_for_power(tgt_i + dir * k * band + jitter));
    end
  endtask

  task automatic noise_items(int unsigned count);
    repeat (count) begin
      send_item(logic'($urandom_range(0, 1)), TgtW'($urandom), AdcW'($urandom),
                ChW'($urandom));
    end
  endtask

  task automatic run_leveling(int unsigned budget);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(0, 9) < 8) leveling_sequence();
      else noise_items($urandom_range(1, 12));
    end
  endtask

  // Foreign-channel sample and an average taken with the loop idle
  task automatic test_ignored_items();
    int unsigned n;
    send_item(ACT_SAMPLE, 15'h7fff, 16'hffff, 4'ha);
    for (n = 0; n < AvgCount; n++) begin
      send_item(ACT_SAMPLE, n[0] ? 15'h7fff : 15'h0000, n[0] ? 16'hffff : 16'h0000,
                cfg_q.channel);
    end
  endtask

  // Average exactly at the target settles; the start lands mid-average
  task automatic test_equal_settle();
    logic [TgtW-1:0] tgt;
    int unsigned n;
    tgt = TgtW'(detector_power(16'd1000));
    for (n = 0; n < AvgCount; n++) begin
      if (n == 3) send_item(ACT_START, tgt, 16'h0000, 4'h0);
      send_item(ACT_SAMPLE, 15'h0000, 16'd1000, cfg_q.channel);
    end
  endtask

  // Restart, then power far above target with the level already at max
  task automatic test_limit_exhausted();
    int unsigned n;
    send_item(ACT_START, 15'h3fff, 16'hffff, 4'hf);
    send_item(ACT_START, 15'h4000, 16'h0000, 4'h0);
    for (n = 0; n < AvgCount; n++) begin
      send_item(ACT_SAMPLE, 15'h3fff, 16'h0000, cfg_q.channel);
    end
  endtask

  task automatic test_default_leveling();
    apply_config(make_cfg(4'd5, 16'd3840, 16'd38400, 6'd1, 6'd63, 6'd0));
    run_leveling(300);
  endtask

  task automatic test_coarse_steps();
    apply_config(make_cfg(4'd15, 16'h7fff, 16'hffff, 6'd63, 6'd63, 6'd0));
    run_leveling(200);
  endtask

  task automatic test_zero_step();
    apply_config(make_cfg(4'd0, 16'h0000, 16'd300, 6'd0, 6'd50, 6'd3));
    run_leveling(200);
  endtask

  task automatic test_flat_detector();
    apply_config(make_cfg(4'd3, 16'h8000, 16'd0, 6'd5, 6'd40, 6'd10));
    run_leveling(150);
  endtask

  task automatic test_crossed_limits();
    apply_config(make_cfg(4'd9, 16'h0000, 16'd20000, 6'd7, 6'd20, 6'd40));
    run_leveling(200);
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      apply_config(make_cfg(ChW'($urandom), PwrW'($urandom), SlopeW'($urandom),
                            AttW'($urandom), AttW'($urandom), AttW'($urandom)));
      run_leveling(250);
    end
  endtask

  initial begin
    cfg_q    = make_cfg(4'd5, 16'd3840, 16'd38400, 6'd1, 6'd63, 6'd0);
    sum_q    = '0;
    count_q  = 0;
    mode_q   = MODE_IDLE;
    level_q  = '1;
    target_q = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_items();
    test_equal_settle();
    test_limit_exhausted();
    test_default_leveling();
    test_coarse_steps();
    test_zero_step();
    test_flat_detector();
    test_crossed_limits();
    test_random_settings();

    wait_idle();
    $display("sent %0d items and checked %0d leveling results over %0d register settings",
             items_sent, reports_checked, settings_used);
    $display("%0d mismatches in %0d cycles", errors, cycles);
    if (errors == 0) begin
      $display("tb_rf_power_leveling_loop passed");
    end else begin
      $display("tb_rf_power_leveling_loop failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rfpl_pkg.sv
rtl/rfpl_level_step.sv
rtl/rf_power_leveling_loop.sv
sim/tb_rf_power_leveling_loop.sv
